// File: src/ihex_pkg.sv
`timescale 1ns / 1ps
// ihex_pkg: shared types, codes and constants for the hex record decoder
// no dependencies; used by the top level and the bench

package ihex_pkg;

  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
  localparam logic [POS_W-1:0] MIN_LEN = 10'd11;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_LINEAR  = 8'h04;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_NO_COLON  = 3'd2,
    ERR_BAD_DIGIT = 3'd3,
    ERR_LENGTH    = 3'd4,
    ERR_CHECKSUM  = 3'd5,
    ERR_BASE_SHORT = 3'd6
  } err_code_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_kind;
    logic [2:0]  error_code;
    logic [31:0] lowest_address;
    logic [31:0] highest_address;
  } result_t;

  // {ok, value}; an invalid digit decodes as zero
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// File: src/ihex_in_if.sv
`timescale 1ns / 1ps
// ihex_in_if: character channel into the decoder, valid/ready handshake
// depends on nothing

interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

// File: src/ihex_out_if.sv
`timescale 1ns / 1ps
// ihex_out_if: result channel out of the decoder, valid/ready handshake
// depends on nothing

interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic [7:0]  record_kind;
  logic [2:0]  error_code;
  logic [31:0] lowest_address;
  logic [31:0] highest_address;

  modport source (output valid, output kind, output address, output data_byte,
                  output record_kind, output error_code, output lowest_address,
                  output highest_address, input ready);
  modport sink (input valid, input kind, input address, input data_byte,
                input record_kind, input error_code, input lowest_address,
                input highest_address, output ready);
endinterface

// File: src/intel_hex_record_decoder.sv
`timescale 1ns / 1ps
// intel_hex_record_decoder: one character per cycle unless the result side stalls
// a taken character is registered in the input register, and its result (if any)
//   in the result register; both registers move each cycle unless the result
//   side stalls
// reset: synchronous active-low rst_n clears line state, base, marks and error
// depends on ihex_pkg, ihex_in_if, ihex_out_if

module intel_hex_record_decoder
  import ihex_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ihex_in_if.sink      in_ch,
  ihex_out_if.source   out_ch
);

  // input and result stage
  logic            in_valid_r, in_valid_nxt;
  logic [7:0]      char_r, char_nxt;
  logic            out_valid_r, out_valid_nxt;
  result_t         out_word_r, out_word_nxt;

  // decoder state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       nib_r, nib_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [15:0]      ofs_r, ofs_nxt;
  logic [7:0]       typ_r, typ_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      bb_r, bb_nxt;
  logic [31:0]      base_r, base_nxt;
  logic [31:0]      low_r, low_nxt;
  logic [31:0]      high_r, high_nxt;
  logic             err_r, err_nxt;
  logic             colon_r, colon_nxt;
  logic             head_bad_r, head_bad_nxt;
  logic             body_bad_r, body_bad_nxt;

  logic             advance;
  logic             res_valid;
  result_t          res;

  logic [POS_W-1:0] twice_cnt;
  logic [POS_W-1:0] full_len;
  logic [4:0]       dig;
  logic [7:0]       b;
  logic [7:0]       idx;
  logic [2:0]       code;
  logic [31:0]      start;
  logic [31:0]      last;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  assign twice_cnt = {1'b0, cnt_r, 1'b0};
  assign full_len  = MIN_LEN + twice_cnt;
  assign dig       = hex_nibble(char_r);
  assign b         = {nib_r, dig[3:0]};
  assign idx       = pos_r[8:1] - 8'd5;
  assign start     = base_r + {16'd0, ofs_r};
  assign last      = start + {24'd0, cnt_r} - 32'd1;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    char_nxt      = char_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    pos_nxt       = pos_r;
    nib_nxt       = nib_r;
    cnt_nxt       = cnt_r;
    ofs_nxt       = ofs_r;
    typ_nxt       = typ_r;
    sum_nxt       = sum_r;
    bb_nxt        = bb_r;
    base_nxt      = base_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    err_nxt       = err_r;
    colon_nxt     = colon_r;
    head_bad_nxt  = head_bad_r;
    body_bad_nxt  = body_bad_r;
    res_valid     = 1'b0;
    res           = '0;
    code          = ERR_NONE;

    if (in_ch.ready) begin
      in_valid_nxt = in_ch.valid;
      if (in_ch.valid) begin
        char_nxt = in_ch.character;
      end
    end

    if (advance && char_r != CHAR_CR) begin
      if (char_r == CHAR_LF) begin
        if (!err_r) begin
          if (pos_r < MIN_LEN - 10'd1) begin
            code = ERR_SHORT;
          end else if (!colon_r) begin
            code = ERR_NO_COLON;
          end else if (head_bad_r) begin
            code = ERR_BAD_DIGIT;
          end else if (typ_r != REC_EOF) begin
            if (pos_r != full_len) begin
              code = ERR_LENGTH;
            end else if (body_bad_r) begin
              code = ERR_BAD_DIGIT;
            end else if (sum_r != 8'd0) begin
              code = ERR_CHECKSUM;
            end else if ((typ_r == REC_SEGMENT || typ_r == REC_LINEAR) && cnt_r < 8'd2) begin
              code = ERR_BASE_SHORT;
            end
          end
          res_valid       = 1'b1;
          res.record_kind = typ_r;
          if (code != ERR_NONE) begin
            err_nxt            = 1'b1;
            res.kind           = KIND_ERROR;
            res.error_code     = code;
            res.lowest_address  = low_r;
            res.highest_address = high_r;
          end else begin
            if (typ_r == REC_DATA && cnt_r != 8'd0) begin
              if (start < low_r) low_nxt = start;
              if (last > high_r) high_nxt = last;
            end else if (typ_r == REC_SEGMENT) begin
              base_nxt = {12'd0, bb_r, 4'd0};
            end else if (typ_r == REC_LINEAR) begin
              base_nxt = {bb_r, 16'd0};
            end
            res.kind            = KIND_RECORD;
            res.lowest_address  = low_nxt;
            res.highest_address = high_nxt;
          end
        end
        // line state starts over
        pos_nxt      = '0;
        nib_nxt      = '0;
        cnt_nxt      = '0;
        ofs_nxt      = '0;
        typ_nxt      = '0;
        sum_nxt      = '0;
        bb_nxt       = '0;
        colon_nxt    = 1'b0;
        head_bad_nxt = 1'b0;
        body_bad_nxt = 1'b0;
      end else begin
        if (pos_r < POS_MAX) pos_nxt = pos_r + 10'd1;
        if (pos_r == '0) begin
          colon_nxt = (char_r == CHAR_COLON);
        end else if (pos_r > 10'd8 && (typ_r == REC_EOF || pos_r > full_len - 10'd1)) begin
          // eof body or trailing characters: only counted
        end else begin
          if (!dig[4]) begin
            if (pos_r <= 10'd8) head_bad_nxt = 1'b1;
            else body_bad_nxt = 1'b1;
          end
          if (pos_r[0]) begin
            nib_nxt = dig[3:0];
          end else begin
            sum_nxt = sum_r + b;
            if (pos_r == 10'd2) begin
              cnt_nxt = b;
            end else if (pos_r == 10'd4) begin
              ofs_nxt = {b, ofs_r[7:0]};
            end else if (pos_r == 10'd6) begin
              ofs_nxt = {ofs_r[15:8], b};
            end else if (pos_r == 10'd8) begin
              typ_nxt = b;
            end else if (pos_r <= full_len - 10'd3) begin
              if (idx == 8'd0) bb_nxt = {b, bb_r[7:0]};
              else if (idx == 8'd1) bb_nxt = {bb_r[15:8], b};
              if (typ_r == REC_DATA && colon_r && !err_r) begin
                res_valid           = 1'b1;
                res.kind            = KIND_DATA;
                res.address         = start + {24'd0, idx};
                res.data_byte       = b;
                res.record_kind     = typ_r;
                res.lowest_address  = low_r;
                res.highest_address = high_r;
              end
            end
          end
        end
      end
    end

    if (advance) begin
      out_valid_nxt = res_valid;
      if (res_valid) out_word_nxt = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      nib_r       <= '0;
      cnt_r       <= '0;
      ofs_r       <= '0;
      typ_r       <= '0;
      sum_r       <= '0;
      bb_r        <= '0;
      base_r      <= '0;
      low_r       <= '1;
      high_r      <= '0;
      err_r       <= 1'b0;
      colon_r     <= 1'b0;
      head_bad_r  <= 1'b0;
      body_bad_r  <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      nib_r       <= nib_nxt;
      cnt_r       <= cnt_nxt;
      ofs_r       <= ofs_nxt;
      typ_r       <= typ_nxt;
      sum_r       <= sum_nxt;
      bb_r        <= bb_nxt;
      base_r      <= base_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      err_r       <= err_nxt;
      colon_r     <= colon_nxt;
      head_bad_r  <= head_bad_nxt;
      body_bad_r  <= body_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = out_word_r.kind;
  assign out_ch.address         = out_word_r.address;
  assign out_ch.data_byte       = out_word_r.data_byte;
  assign out_ch.record_kind     = out_word_r.record_kind;
  assign out_ch.error_code      = out_word_r.error_code;
  assign out_ch.lowest_address  = out_word_r.lowest_address;
  assign out_ch.highest_address = out_word_r.highest_address;

  // once the error is out, nothing else is produced
  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> !(advance && res_valid))
    else $error("result produced after latched error");

  // an error result always carries a nonzero code, others carry none
  a_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_word_r.kind == KIND_ERROR) == (out_word_r.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // data words only come from data records
  a_data_from_type0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.kind == KIND_DATA) |-> out_word_r.record_kind == REC_DATA)
    else $error("data word from a non-data record");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // the error flag only rises together with an error result
  a_error_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!err_r && err_nxt) |=> (out_valid_r && out_word_r.kind == KIND_ERROR))
    else $error("error latched without error result");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for the intel hex record decoder, fed text one character at a time
// depends on ihex_pkg, ihex_in_if, ihex_out_if and intel_hex_record_decoder

module tb;
  import ihex_pkg::*;

  typedef logic [7:0] octets_t[$];

  logic clk;
  logic rst_n;

  ihex_in_if  in_ch();
  ihex_out_if out_ch();

  intel_hex_record_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decoder state as the bench tracks it
  int          line_pos;
  logic [3:0]  high_nibble;
  logic [7:0]  rec_len;
  logic [15:0] rec_offset;
  logic [7:0]  rec_type;
  logic [7:0]  line_sum;
  logic [15:0] base_field;
  logic [31:0] base_addr;
  logic [31:0] low_mark;
  logic [31:0] high_mark;
  logic        error_seen;
  logic        colon_ok;
  logic        head_bad;
  logic        body_bad;

  result_t decoded_words[$];

  int gap_pct;
  int stall_pct;
  int cr_pct;
  int hold_request;
  int chars_sent;
  int lines_sent;
  int words_checked;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic result_t make_word(input kind_t k, input logic [31:0] addr,
                                        input logic [7:0] value, input err_code_t code);
    result_t w;
    w.kind            = k;
    w.address         = addr;
    w.data_byte       = value;
    w.record_kind     = rec_type;
    w.error_code      = code;
    w.lowest_address  = low_mark;
    w.highest_address = high_mark;
    return w;
  endfunction

  task automatic expect_word(input result_t w);
    decoded_words.insert(decoded_words.size(), w);
  endtask

  task automatic clear_line_state();
    line_pos    = 0;
    high_nibble = '0;
    rec_len     = '0;
    rec_offset  = '0;
    rec_type    = '0;
    line_sum    = '0;
    base_field  = '0;
    colon_ok    = 1'b0;
    head_bad    = 1'b0;
    body_bad    = 1'b0;
  endtask

  // judge the finished line, apply base records and update the address marks
  task automatic close_line();
    err_code_t   code;
    logic [31:0] first_addr;
    logic [31:0] last_addr;
    if (!error_seen) begin
      code = ERR_NONE;
      if (line_pos + 1 < int'(MIN_LEN)) begin
        code = ERR_SHORT;
      end else if (!colon_ok) begin
        code = ERR_NO_COLON;
      end else if (head_bad) begin
        code = ERR_BAD_DIGIT;
      end else if (rec_type != REC_EOF) begin
        if (line_pos != int'(MIN_LEN) + 2 * int'(rec_len)) begin
          code = ERR_LENGTH;
        end else if (body_bad) begin
          code = ERR_BAD_DIGIT;
        end else if (line_sum != 8'h00) begin
          code = ERR_CHECKSUM;
        end else if ((rec_type == REC_SEGMENT || rec_type == REC_LINEAR) && rec_len < 8'd2) begin
          code = ERR_BASE_SHORT;
        end
      end
      if (code != ERR_NONE) begin
        error_seen = 1'b1;
        expect_word(make_word(KIND_ERROR, '0, '0, code));
      end else begin
        if (rec_type == REC_DATA && rec_len != 8'd0) begin
          first_addr = base_addr + {16'h0000, rec_offset};
          last_addr  = first_addr + {24'h0, rec_len} - 32'd1;
          if (first_addr < low_mark) low_mark = first_addr;
          if (last_addr > high_mark) high_mark = last_addr;
        end else if (rec_type == REC_SEGMENT) begin
          base_addr = {12'h000, base_field, 4'h0};
        end else if (rec_type == REC_LINEAR) begin
          base_addr = {base_field, 16'h0000};
        end
        expect_word(make_word(KIND_RECORD, '0, '0, ERR_NONE));
      end
    end
    clear_line_state();
  endtask

  task automatic decode_hex_char(input logic [7:0] c);
    int         p;
    int         idx;
    logic [3:0] nib;
    logic       ok;
    logic [7:0] b;
    if (c == CHAR_CR) return;
    if (c == CHAR_LF) begin
      close_line();
      return;
    end
    p = line_pos;
    if (line_pos < int'(POS_MAX)) line_pos++;
    if (p == 0) begin
      colon_ok = (c == CHAR_COLON);
      return;
    end
    // end of file records ignore everything after the type; past the checksum only counts
    if (p > 8 && (rec_type == REC_EOF || p > 10 + 2 * int'(rec_len))) return;
    ok  = 1'b1;
    nib = 4'h0;
    if (c >= "0" && c <= "9") begin
      nib = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      nib = 4'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      nib = 4'(c - "a" + 8'd10);
    end else begin
      ok = 1'b0;
    end
    if (!ok) begin
      if (p <= 8) head_bad = 1'b1;
      else body_bad = 1'b1;
    end
    if (p % 2 == 1) begin
      high_nibble = nib;
      return;
    end
    b = {high_nibble, nib};
    line_sum = line_sum + b;
    if (p == 2) begin
      rec_len = b;
    end else if (p == 4) begin
      rec_offset[15:8] = b;
    end else if (p == 6) begin
      rec_offset[7:0] = b;
    end else if (p == 8) begin
      rec_type = b;
    end else if (p <= 8 + 2 * int'(rec_len)) begin
      idx = (p - 10) / 2;
      if (idx == 0) base_field[15:8] = b;
      else if (idx == 1) base_field[7:0] = b;
      if (rec_type == REC_DATA && colon_ok && !error_seen) begin
        expect_word(make_word(KIND_DATA,
          base_addr + {16'h0000, rec_offset} + 32'(idx), b, ERR_NONE));
      end
    end
  endtask

  // called and returns just after a falling edge
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid     = 1'b0;
      in_ch.character = 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.character = c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_hex_char(c);
    chars_sent++;
    if (c == CHAR_LF) lines_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit lower);
    if ($urandom_range(99) < cr_pct) send_char(CHAR_CR);
    send_char(hex_char(b[7:4], lower));
    send_char(hex_char(b[3:0], lower));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // junk goes after the checksum and never holds a line feed
  task automatic send_record(input logic [7:0] rtype, input logic [15:0] offs,
                             input octets_t body, input bit lower, input int junk,
                             input bit with_cr);
    logic [7:0] sum;
    logic [7:0] c;
    sum = 8'(body.size()) + offs[15:8] + offs[7:0] + rtype;
    foreach (body[i]) sum = sum + body[i];
    send_char(CHAR_COLON);
    send_byte(8'(body.size()), lower);
    send_byte(offs[15:8], lower);
    send_byte(offs[7:0], lower);
    send_byte(rtype, lower);
    foreach (body[i]) send_byte(body[i], lower);
    send_byte(8'(-sum), lower);
    for (int i = 0; i < junk; i++) begin
      c = 8'($urandom_range(255));
      if (c == CHAR_LF) c = CHAR_COLON;
      send_char(c);
    end
    if (with_cr) send_char(CHAR_CR);
    send_char(CHAR_LF);
  endtask

  function automatic octets_t random_body(input int n);
    octets_t q;
    for (int i = 0; i < n; i++) q.insert(q.size(), 8'($urandom_range(255)));
    return q;
  endfunction

  // the n low bytes of v, most significant first
  function automatic octets_t octets_from(input logic [31:0] v, input int n);
    octets_t q;
    for (int i = n - 1; i >= 0; i--) q.insert(q.size(), v[8*i +: 8]);
    return q;
  endfunction

  task automatic wait_all_words();
    in_ch.valid = 1'b0;
    while (decoded_words.size() != 0) @(negedge clk);
  endtask

  task automatic test_record_types();
    octets_t none;
    gap_pct   = 0;
    stall_pct = 0;
    cr_pct    = 0;
    send_record(REC_DATA, 16'h0000, none, 1'b0, 0, 1'b1);
    send_record(REC_DATA, 16'h0000, octets_from(32'h0, 1), 1'b0, 0, 1'b1);
    send_record(REC_DATA, 16'hFFFF, octets_from(32'hFFFFFFFF, 4), 1'b1, 0, 1'b1);
    // linear base at the top of memory, then an address run that wraps past zero
    send_record(REC_LINEAR, 16'h0000, octets_from(32'hFFFF, 2), 1'b0, 0, 1'b1);
    send_record(REC_DATA, 16'hFFFF, octets_from(32'h5AA580, 3), 1'b0, 0, 1'b1);
    // segment base with an extra byte; the whole 16-bit offset counts
    send_record(REC_SEGMENT, 16'h0000, octets_from(32'h123456, 3), 1'b1, 0, 1'b1);
    send_record(REC_DATA, 16'hFFFF, octets_from(32'h1122, 2), 1'b0, 0, 1'b1);
    send_record(REC_SEGMENT, 16'h0000, octets_from(32'hFFFF, 2), 1'b0, 0, 1'b1);
    send_record(REC_DATA, 16'h8001, random_body(5), 1'b1, 0, 1'b1);
    send_record(REC_LINEAR, 16'h0000, octets_from(32'h0000, 2), 1'b0, 0, 1'b1);
    // other record types are accepted and do nothing
    send_record(8'h03, 16'h0000, octets_from(32'h1234, 2), 1'b0, 0, 1'b1);
    send_record(8'h05, 16'h0000, octets_from(32'h0100, 2), 1'b0, 0, 1'b1);
    send_record(8'hFF, 16'hFFFF, octets_from(32'hA5, 1), 1'b1, 0, 1'b1);
    send_record(REC_DATA, 16'($urandom), random_body(6), 1'b0, 0, 1'b1);
    send_record(REC_DATA, 16'h0100, random_body(4), 1'b1, 0, 1'b0);
    send_record(REC_EOF, 16'h0000, none, 1'b0, 0, 1'b1);
    wait_all_words();
  endtask

  task automatic test_eof_trailing_text();
    octets_t none;
    send_record(REC_EOF, 16'h0000, none, 1'b1, 10, 1'b1);
    send_record(REC_EOF, 16'hABCD, random_body(3), 1'b0, 0, 1'b1);
    send_record(REC_DATA, 16'h0040, random_body(4), 1'b0, 0, 1'b1);
    wait_all_words();
  endtask

  task automatic test_output_holdoff();
    gap_pct      = 0;
    stall_pct    = 0;
    hold_request = 200;
    send_record(REC_DATA, 16'($urandom), random_body(12), 1'b0, 0, 1'b1);
    wait_all_words();
  endtask

  task automatic send_random_record();
    int         pick;
    int         n;
    logic [7:0] rtype;
    octets_t    none;
    pick  = $urandom_range(99);
    n     = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
    if ($urandom_range(29) == 0) n = $urandom_range(13, 24);
    rtype = REC_DATA;
    if (pick >= 60 && pick < 70) begin
      rtype = REC_LINEAR;
      n     = $urandom_range(2, 3);
    end else if (pick >= 70 && pick < 80) begin
      rtype = REC_SEGMENT;
      n     = $urandom_range(2, 3);
    end else if (pick >= 80 && pick < 88) begin
      send_record(REC_EOF, 16'($urandom), none, 1'($urandom_range(1)), $urandom_range(20),
                  $urandom_range(3) != 0);
      return;
    end else if (pick >= 88) begin
      rtype = 8'($urandom_range(3, 255));
      if (rtype == REC_LINEAR) rtype = rtype + 8'd1;
      n = $urandom_range(4);
    end
    send_record(rtype, 16'($urandom), random_body(n), 1'($urandom_range(1)), 0,
                $urandom_range(3) != 0);
  endtask

  task automatic test_random_lines();
    int goal;
    cr_pct = 3;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      goal = chars_sent + 25;
      while (chars_sent < goal) send_random_record();
      wait_all_words();
    end
    cr_pct = 0;
  endtask

  // only one error can ever be reported, so a single bad line is picked per run
  task automatic test_sticky_error();
    string bad_lines[8];
    int    pick;
    bad_lines[0] = ":000000";
    bad_lines[1] = "?00000000FF";
    bad_lines[2] = ":0G00000000";
    bad_lines[3] = ":0100000000FF00";
    bad_lines[4] = ":01000000ZZFF";
    bad_lines[5] = ":0100000012FF";
    bad_lines[6] = ":0100000412E9";
    // largest byte count on a line far too short for it
    bad_lines[7] = ":FF0000000000";
    pick      = $urandom_range(7);
    gap_pct   = 20;
    stall_pct = 20;
    send_text(bad_lines[pick]);
    send_char(CHAR_CR);
    send_char(CHAR_LF);
    // everything after the error must be swallowed silently
    for (int i = 0; i < 24; i++) send_char(8'($urandom_range(255)));
    send_char(CHAR_LF);
    send_record(REC_DATA, 16'h0010, random_body(4), 1'b0, 0, 1'b1);
    wait_all_words();
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_words
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (decoded_words.size() == 0) begin
        report_mismatch("word with nothing expected, kind", 32'(out_ch.kind), '0);
      end else begin
        want = decoded_words.pop_front();
        words_checked++;
        if (out_ch.kind !== want.kind)
          report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
        if (out_ch.address !== want.address)
          report_mismatch("address", out_ch.address, want.address);
        if (out_ch.data_byte !== want.data_byte)
          report_mismatch("data_byte", 32'(out_ch.data_byte), 32'(want.data_byte));
        if (out_ch.record_kind !== want.record_kind)
          report_mismatch("record_kind", 32'(out_ch.record_kind), 32'(want.record_kind));
        if (out_ch.error_code !== want.error_code)
          report_mismatch("error_code", 32'(out_ch.error_code), 32'(want.error_code));
        if (out_ch.lowest_address !== want.lowest_address)
          report_mismatch("lowest_address", out_ch.lowest_address, want.lowest_address);
        if (out_ch.highest_address !== want.highest_address)
          report_mismatch("highest_address", out_ch.highest_address, want.highest_address);
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.character = '0;
    gap_pct         = 0;
    stall_pct       = 0;
    cr_pct          = 0;
    hold_request    = 0;
    chars_sent      = 0;
    lines_sent      = 0;
    words_checked   = 0;
    mismatches      = 0;
    clear_line_state();
    base_addr   = '0;
    low_mark    = 32'hFFFF_FFFF;
    high_mark   = '0;
    error_seen  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_record_types();
    test_eof_trailing_text();
    test_output_holdoff();
    test_random_lines();
    test_sticky_error();

    repeat (4) @(negedge clk);
    if (decoded_words.size() != 0)
      report_mismatch("words never produced", '0, 32'(decoded_words.size()));
    $display("run covered %0d characters in %0d lines, %0d result words checked",
             chars_sent, lines_sent, words_checked);
    $display("all record types, base records, address wrap and one sticky error exercised");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
